// ===== hdl/sdq_pkg.sv =====
`default_nettype none

package sdq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int OCC_W        = 5;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_REM_MIN = 2'd1,
        FUNC_REM_MAX = 2'd2,
        FUNC_SEARCH  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_func                      func;
        logic signed [VALUE_W-1:0]  value;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value_out;
        t_status                    status;
        logic                       found;
        logic [OCC_W-1:0]           occupancy;
    } t_out;

    // datapath command fields
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_COUNT,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_ZERO,
        RD_COUNT_M1,
        RD_IDX_P1,
        RD_IDX_M2
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_IDX_VAL,
        WR_IDX_RDATA,
        WR_IDXM1_RDATA
    } t_wr_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_OK_VAL,
        RES_OK_RDATA,
        RES_EMPTY,
        RES_FULL,
        RES_FOUND,
        RES_MISS
    } t_res_op;

    typedef struct packed {
        logic       load;
        t_idx_op    idx_op;
        t_rd_sel    rd_sel;
        t_wr_sel    wr_sel;
        t_cnt_op    cnt_op;
        t_res_op    res_op;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic   empty;
        logic   full;
        logic   idx_zero;
        logic   idx_last;
        logic   rd_gt;
        logic   rd_eq;
        logic   out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/sdq_datapath.sv =====
`default_nettype none

module sdq_datapath #(
    parameter int CAPACITY = sdq_pkg::CAPACITY_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire sdq_pkg::t_dp_cmd                   i_cmd,
    input  wire logic signed [sdq_pkg::VALUE_W-1:0] i_value,
    output sdq_pkg::t_dp_sts                        o_sts,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output sdq_pkg::t_out                           o_out_data
);
    import sdq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] r_mem [CAPACITY];
    logic signed [VALUE_W-1:0] r_rdata;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic [CW-1:0]             r_idx, n_idx;
    logic [CW-1:0]             r_count, n_count;
    logic signed [VALUE_W-1:0] r_res_value, n_res_value;
    t_status                   r_res_status, n_res_status;
    logic                      r_res_found, n_res_found;
    logic                      r_out_valid;
    t_out                      r_out;

    logic [CW-1:0]             idx_p1, idx_m1, idx_m2, cnt_m1;
    logic                      rd_en, wr_en;
    logic [AW-1:0]             rd_addr, wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      out_free;

    assign idx_p1 = r_idx + CW'(1);
    assign idx_m1 = r_idx - CW'(1);
    assign idx_m2 = r_idx - CW'(2);
    assign cnt_m1 = r_count - CW'(1);

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_NONE: begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
            RD_ZERO: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            RD_COUNT_M1: begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
            end
            RD_IDX_P1: begin
                rd_en   = 1'b1;
                rd_addr = idx_p1[AW-1:0];
            end
            RD_IDX_M2: begin
                rd_en   = 1'b1;
                rd_addr = idx_m2[AW-1:0];
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_NONE: begin
                wr_en   = 1'b0;
                wr_addr = r_idx[AW-1:0];
                wr_data = r_val;
            end
            WR_IDX_VAL: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                wr_data = r_val;
            end
            WR_IDX_RDATA: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                wr_data = r_rdata;
            end
            WR_IDXM1_RDATA: begin
                wr_en   = 1'b1;
                wr_addr = idx_m1[AW-1:0];
                wr_data = r_rdata;
            end
            default: begin
                wr_en   = 1'b0;
                wr_addr = r_idx[AW-1:0];
                wr_data = r_val;
            end
        endcase
    end

    always_comb begin
        n_val = i_cmd.load ? i_value : r_val;

        unique case (i_cmd.idx_op)
            IDX_HOLD:       n_idx = r_idx;
            IDX_LOAD_COUNT: n_idx = r_count;
            IDX_ZERO:       n_idx = '0;
            IDX_INC:        n_idx = idx_p1;
            IDX_DEC:        n_idx = idx_m1;
            default:        n_idx = r_idx;
        endcase

        unique case (i_cmd.cnt_op)
            CNT_HOLD: n_count = r_count;
            CNT_INC:  n_count = r_count + CW'(1);
            CNT_DEC:  n_count = cnt_m1;
            default:  n_count = r_count;
        endcase

        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        unique case (i_cmd.res_op)
            RES_NONE: ;
            RES_OK_VAL: begin
                n_res_value  = r_val;
                n_res_status = ST_OK;
                n_res_found  = 1'b0;
            end
            RES_OK_RDATA: begin
                n_res_value  = r_rdata;
                n_res_status = ST_OK;
                n_res_found  = 1'b0;
            end
            RES_EMPTY: begin
                n_res_value  = '0;
                n_res_status = ST_EMPTY;
                n_res_found  = 1'b0;
            end
            RES_FULL: begin
                n_res_value  = '0;
                n_res_status = ST_FULL;
                n_res_found  = 1'b0;
            end
            RES_FOUND: begin
                n_res_value  = '0;
                n_res_status = ST_OK;
                n_res_found  = 1'b1;
            end
            RES_MISS: begin
                n_res_value  = '0;
                n_res_status = ST_OK;
                n_res_found  = 1'b0;
            end
            default: ;
        endcase
    end

    // entry store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        if (i_cmd.emit) begin
            r_out.value_out <= r_res_value;
            r_out.status    <= r_res_status;
            r_out.found     <= r_res_found;
            r_out.occupancy <= OCC_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(CAPACITY));
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.idx_last = (idx_p1 == r_count);
    assign o_sts.rd_gt    = (r_rdata > r_val);
    assign o_sts.rd_eq    = (r_rdata == r_val);
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (CW'(wr_addr) <= r_count) && (r_count != CW'(CAPACITY)
                                               || CW'(wr_addr) < r_count))
        else $error("write outside the occupied region");

    a_emit_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> o_out_valid && (o_out_data.occupancy == $past(OCC_W'(r_count))))
        else $error("result occupancy does not match entry count");

endmodule

`default_nettype wire

// ===== hdl/sdq_ctrl.sv =====
`default_nettype none

module sdq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire sdq_pkg::t_func   i_func,
    input  wire sdq_pkg::t_dp_sts i_sts,
    output sdq_pkg::t_dp_cmd      o_cmd
);
    import sdq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,
        S_MIN  = 6'b000100,
        S_MAX  = 6'b001000,
        S_SRCH = 6'b010000,
        S_RESP = 6'b100000
    } t_state;

    t_state  r_state, n_state;
    t_dp_cmd cmd;

    always_comb begin
        n_state    = r_state;
        cmd.load   = 1'b0;
        cmd.idx_op = IDX_HOLD;
        cmd.rd_sel = RD_NONE;
        cmd.wr_sel = WR_NONE;
        cmd.cnt_op = CNT_HOLD;
        cmd.res_op = RES_NONE;
        cmd.emit   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    unique case (i_func)
                        FUNC_INSERT: begin
                            if (i_sts.full) begin
                                cmd.res_op = RES_FULL;
                                n_state    = S_RESP;
                            end else begin
                                cmd.idx_op = IDX_LOAD_COUNT;
                                cmd.rd_sel = RD_COUNT_M1;
                                n_state    = S_INS;
                            end
                        end
                        FUNC_REM_MIN: begin
                            if (i_sts.empty) begin
                                cmd.res_op = RES_EMPTY;
                                n_state    = S_RESP;
                            end else begin
                                cmd.idx_op = IDX_ZERO;
                                cmd.rd_sel = RD_ZERO;
                                n_state    = S_MIN;
                            end
                        end
                        FUNC_REM_MAX: begin
                            if (i_sts.empty) begin
                                cmd.res_op = RES_EMPTY;
                                n_state    = S_RESP;
                            end else begin
                                cmd.rd_sel = RD_COUNT_M1;
                                n_state    = S_MAX;
                            end
                        end
                        FUNC_SEARCH: begin
                            if (i_sts.empty) begin
                                cmd.res_op = RES_MISS;
                                n_state    = S_RESP;
                            end else begin
                                cmd.idx_op = IDX_ZERO;
                                cmd.rd_sel = RD_ZERO;
                                n_state    = S_SRCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // walk down from the top, moving larger entries up one place
            S_INS: begin
                if (!i_sts.idx_zero && i_sts.rd_gt) begin
                    cmd.wr_sel = WR_IDX_RDATA;
                    cmd.idx_op = IDX_DEC;
                    cmd.rd_sel = RD_IDX_M2;
                end else begin
                    cmd.wr_sel = WR_IDX_VAL;
                    cmd.cnt_op = CNT_INC;
                    cmd.res_op = RES_OK_VAL;
                    n_state    = S_RESP;
                end
            end
            // first beat captures the minimum, the rest move entries down
            S_MIN: begin
                if (i_sts.idx_zero) begin
                    cmd.res_op = RES_OK_RDATA;
                end else begin
                    cmd.wr_sel = WR_IDXM1_RDATA;
                end
                if (i_sts.idx_last) begin
                    cmd.cnt_op = CNT_DEC;
                    n_state    = S_RESP;
                end else begin
                    cmd.rd_sel = RD_IDX_P1;
                    cmd.idx_op = IDX_INC;
                end
            end
            S_MAX: begin
                cmd.res_op = RES_OK_RDATA;
                cmd.cnt_op = CNT_DEC;
                n_state    = S_RESP;
            end
            S_SRCH: begin
                if (i_sts.rd_eq) begin
                    cmd.res_op = RES_FOUND;
                    n_state    = S_RESP;
                end else if (i_sts.idx_last) begin
                    cmd.res_op = RES_MISS;
                    n_state    = S_RESP;
                end else begin
                    cmd.rd_sel = RD_IDX_P1;
                    cmd.idx_op = IDX_INC;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // no transfer is taken while reset is held
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign o_cmd      = cmd;

    a_no_inc_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.cnt_op == CNT_INC) |-> !i_sts.full)
        else $error("insert committed into a full store");

    a_no_dec_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.cnt_op == CNT_DEC) |-> !i_sts.empty)
        else $error("removal committed from an empty store");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

// ===== hdl/sorted_double_ended_queue.sv =====
`default_nettype none

// channel  valid        ready        data
// input    i_in_valid   o_in_ready   i_in_data  (func, value)
// output   o_out_valid  i_out_ready  o_out_data (value_out, status, found, occupancy)
//
// One operation at a time; the entry memory has a single read port, so work
// goes one entry per cycle. An insert walks down past the entries larger than
// the value, remove-min moves every later entry down, remove-max reads the top
// entry, and a search scans upward until a match or the last entry.
// A finished result sits in the output register while the next item is taken.
// Synchronous active-low reset empties the store; the memory is not cleared.
// The output register stalls the controller only when a result is untaken.

module sorted_double_ended_queue #(
    parameter int CAPACITY = sdq_pkg::CAPACITY_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire sdq_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output sdq_pkg::t_out       o_out_data
);
    import sdq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    sdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_in_data.func),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sdq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_in_data.value),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import sdq_pkg::*;

    localparam int DEPTH      = CAPACITY_DEF;
    localparam int LONG_HOLD  = 80;
    localparam int N_RANDOM   = 1800;
    localparam int DRAIN_WAIT = 40;

    typedef struct packed {
        t_in  stim;
        logic typed;
        t_out want;
    } t_row;

    // typed rows carry their result; the rest are left to the predictor
    localparam t_row DIRECTED [25] = '{
        '{'{FUNC_REM_MIN, 32'sh0},         1'b1, '{32'sh0, ST_EMPTY, 1'b0, 5'd0}},
        '{'{FUNC_REM_MAX, 32'shFFFF_FFFF}, 1'b1, '{32'sh0, ST_EMPTY, 1'b0, 5'd0}},
        '{'{FUNC_SEARCH,  32'sh0},         1'b1, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'sh7FFF_FFFF}, 1'b1, '{32'sh7FFF_FFFF, ST_OK, 1'b0, 5'd1}},
        '{'{FUNC_INSERT,  32'sh8000_0000}, 1'b1, '{32'sh8000_0000, ST_OK, 1'b0, 5'd2}},
        '{'{FUNC_INSERT,  32'sh0},         1'b1, '{32'sh0, ST_OK, 1'b0, 5'd3}},
        '{'{FUNC_INSERT,  32'sh0},         1'b1, '{32'sh0, ST_OK, 1'b0, 5'd4}},
        '{'{FUNC_SEARCH,  32'sh0},         1'b1, '{32'sh0, ST_OK, 1'b1, 5'd4}},
        '{'{FUNC_SEARCH,  32'shFFFF_FFFF}, 1'b1, '{32'sh0, ST_OK, 1'b0, 5'd4}},
        '{'{FUNC_SEARCH,  32'sh8000_0000}, 1'b1, '{32'sh0, ST_OK, 1'b1, 5'd4}},
        '{'{FUNC_INSERT,  32'shFFFF_FFFF}, 1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'sh1},         1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'sh5},         1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'shFFFF_FFFB}, 1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'sh5555_5555}, 1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'shAAAA_AAAA}, 1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'sh7FFF_FFFF}, 1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'sh8000_0001}, 1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'sh3},         1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'sh3},         1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'shFFFF_FF9C}, 1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'sh64},        1'b0, '{32'sh0, ST_OK, 1'b0, 5'd0}},
        '{'{FUNC_INSERT,  32'sh2A},        1'b1, '{32'sh0, ST_FULL, 1'b0, 5'd16}},
        '{'{FUNC_REM_MAX, 32'sh1234_5678}, 1'b1, '{32'sh7FFF_FFFF, ST_OK, 1'b0, 5'd15}},
        '{'{FUNC_REM_MIN, 32'shEDCB_A987}, 1'b1, '{32'sh8000_0000, ST_OK, 1'b0, 5'd14}}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    sorted_double_ended_queue #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // shadow of the stored multiset, ascending
    logic signed [VALUE_W-1:0] ordered_vals [$];
    t_out pending_results [$];
    t_out got_result;
    t_out want_result;

    int  n_err;
    int  n_results;
    int  n_ops [4];
    int  n_full;
    int  n_empty;
    int  n_hits;
    int  n_holds;
    bit  hold_req;
    bit  sender_quiet;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic t_out store_apply(t_in op);
        t_out r;
        int   pos;
        r = '0;
        case (op.func)
            FUNC_INSERT: begin
                if (ordered_vals.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    // equal values stay ahead of the new one
                    while (pos < ordered_vals.size() && ordered_vals[pos] <= op.value)
                        pos++;
                    ordered_vals.insert(pos, op.value);
                    r.value_out = op.value;
                end
            end
            FUNC_REM_MIN: begin
                if (ordered_vals.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.value_out = ordered_vals.pop_front();
            end
            FUNC_REM_MAX: begin
                if (ordered_vals.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.value_out = ordered_vals.pop_back();
            end
            default: begin
                foreach (ordered_vals[i])
                    if (ordered_vals[i] == op.value)
                        r.found = 1'b1;
            end
        endcase
        r.occupancy = OCC_W'(ordered_vals.size());
        return r;
    endfunction

    function automatic int pick_gap(int cap);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(10, cap);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return VALUE_W'($signed($urandom_range(0, 16)) - 8);
        if (r < 45) begin
            case ($urandom_range(0, 5))
                0: return 32'sh8000_0000;
                1: return 32'sh8000_0001;
                2: return 32'sh7FFF_FFFF;
                3: return 32'sh7FFF_FFFE;
                4: return 32'sh0;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    task automatic transfer_in(t_in item, logic typed, t_out want);
        int   gap;
        t_out r;
        gap = sender_quiet ? 0 : pick_gap(20);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        r = store_apply(item);
        n_ops[item.func]++;
        if (r.status == ST_FULL)
            n_full++;
        if (r.status == ST_EMPTY)
            n_empty++;
        if (r.found)
            n_hits++;
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic flag(string what, logic [31:0] want_v, logic [31:0] got_v);
        n_err++;
        if (n_err <= 100)
            $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            got_result = o_out_data;
            if (pending_results.size() == 0) begin
                flag("unexpected transfer, value_out", 32'h0, got_result.value_out);
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.value_out !== want_result.value_out)
                    flag("value_out", want_result.value_out, got_result.value_out);
                if (got_result.status !== want_result.status)
                    flag("status", want_result.status, got_result.status);
                if (got_result.found !== want_result.found)
                    flag("found", want_result.found, got_result.found);
                if (got_result.occupancy !== want_result.occupancy)
                    flag("occupancy", want_result.occupancy, got_result.occupancy);
            end
        end
    end

    // receiver: random stalls, quiet runs, and one long hold on request
    initial begin
        int stall;
        int run;
        int r;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = LONG_HOLD;
                n_holds++;
            end else begin
                stall = pick_gap(20);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            r   = $urandom_range(0, 99);
            run = (r < 70) ? $urandom_range(1, 3) : $urandom_range(8, 30);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin
        t_in item;
        int  ins_pct;
        int  r;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        hold_req     = 1'b0;
        sender_quiet = 1'b0;
        n_err        = 0;
        n_results    = 0;
        n_full       = 0;
        n_empty      = 0;
        n_hits       = 0;
        n_holds      = 0;
        n_ops        = '{0, 0, 0, 0};
        ins_pct      = 50;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k])
            transfer_in(DIRECTED[k].stim, DIRECTED[k].typed, DIRECTED[k].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            // swing between filling, draining and mixed spells
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: ins_pct = 70;
                    1: ins_pct = 25;
                    default: ins_pct = 45;
                endcase
                sender_quiet = ($urandom_range(0, 3) == 0);
            end
            if (n == 300) begin
                hold_req     = 1'b1;
                sender_quiet = 1'b1;
            end
            item.value = $urandom();
            r = $urandom_range(0, 99);
            if (r < ins_pct) begin
                item.func  = FUNC_INSERT;
                item.value = pick_value();
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: item.func = FUNC_REM_MIN;
                    3, 4, 5: item.func = FUNC_REM_MAX;
                    default: begin
                        item.func = FUNC_SEARCH;
                        if (ordered_vals.size() > 0 && $urandom_range(0, 1))
                            item.value = ordered_vals[$urandom_range(0, ordered_vals.size() - 1)];
                        else
                            item.value = pick_value();
                    end
                endcase
            end
            transfer_in(item, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("ran %0d inserts, %0d min and %0d max removals, %0d searches (%0d hits)",
                 n_ops[FUNC_INSERT], n_ops[FUNC_REM_MIN], n_ops[FUNC_REM_MAX],
                 n_ops[FUNC_SEARCH], n_hits);
        $display("%0d refused as full, %0d as empty, %0d results, %0d long holds, %0d errors",
                 n_full, n_empty, n_results, n_holds, n_err);
        if (n_err == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
